@@ src/moesif_pkg.sv @@
// Shared types and constants for the MOESIF line controller.
// Holds the event and result transfer structs, command, state and request codes.
// Depends on nothing.
package moesif_pkg;

	localparam int ADDR_BITS = 32;
	localparam int ID_BITS   = 4;

	typedef logic [2:0] cmd_t;
	typedef logic [3:0] state_t;
	typedef logic [1:0] req_t;

	localparam cmd_t CMD_LOAD  = 3'd0;
	localparam cmd_t CMD_STORE = 3'd1;
	localparam cmd_t CMD_GETS  = 3'd2;
	localparam cmd_t CMD_GETM  = 3'd3;
	localparam cmd_t CMD_DATA  = 3'd4;

	localparam state_t ST_I   = 4'd0;
	localparam state_t ST_ISE = 4'd1;
	localparam state_t ST_S   = 4'd2;
	localparam state_t ST_E   = 4'd3;
	localparam state_t ST_O   = 4'd4;
	localparam state_t ST_IM  = 4'd5;
	localparam state_t ST_SM  = 4'd6;
	localparam state_t ST_FM  = 4'd7;
	localparam state_t ST_OM  = 4'd8;
	localparam state_t ST_M   = 4'd9;
	localparam state_t ST_F   = 4'd10;

	localparam req_t REQ_NONE = 2'd0;
	localparam req_t REQ_GETS = 2'd1;
	localparam req_t REQ_GETM = 2'd2;

	typedef struct packed {
		cmd_t                 cmd;
		logic [ADDR_BITS-1:0] line_addr;
		logic [ID_BITS-1:0]   requester_id;
		logic                 shared_seen;
	} evt_t;

	typedef struct packed {
		req_t                 bus_request;
		logic                 data_to_processor;
		logic                 data_onto_bus;
		logic [ID_BITS-1:0]   dest_id;
		logic [ADDR_BITS-1:0] addr_out;
		logic                 assert_shared;
		logic                 miss_pulse;
		logic                 upgrade_pulse;
		logic                 protocol_error;
		state_t               line_state;
	} res_t;

endpackage

@@ src/moesif_coherence_line_controller.sv @@
// Top level of the MOESIF coherence controller for one cache line.
// Instantiates moesif_decode; depends on moesif_pkg.
//
// One event is taken per cycle while the event channel does not stall, and each event
// gives exactly one result: the event is captured in an input register, decided
// against the line state in one combinational pass, and the result is then
// registered in an output register. Without output stalls the sustained throughput
// is one event per clock; the line state register is updated as each result is
// registered. The event channel stalls only while the input register holds an
// event and the result register is both full and stalled.
module moesif_coherence_line_controller (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               evt_valid,
	output logic               evt_stall,
	input  moesif_pkg::evt_t   evt,
	output logic               res_valid,
	input  logic               res_stall,
	output moesif_pkg::res_t   res
);
	import moesif_pkg::*;

	logic   valid_s1;
	evt_t   evt_s1;
	logic   res_valid_q;
	res_t   res_q;
	state_t state_q;
	res_t   dec_res;
	logic   advance;

	assign advance   = !res_valid_q || !res_stall;
	assign evt_stall = valid_s1 && !advance;

	moesif_decode u_decode (
		.state (state_q),
		.evt   (evt_s1),
		.res   (dec_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			state_q     <= ST_I;
		end else begin
			if (!evt_stall) begin
				valid_s1 <= evt_valid;
			end
			if (advance) begin
				res_valid_q <= valid_s1;
				if (valid_s1) begin
					state_q <= dec_res.line_state;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!evt_stall && evt_valid) begin
			evt_s1 <= evt;
		end
		if (advance && valid_s1) begin
			res_q <= dec_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

@@ src/moesif_decode.sv @@
// Combinational protocol decision for one event against the current line state.
// Produces the full result, whose line_state is the next state of the line.
// Depends on moesif_pkg.
module moesif_decode (
	input  moesif_pkg::state_t state,
	input  moesif_pkg::evt_t   evt,
	output moesif_pkg::res_t   res
);
	import moesif_pkg::*;

	state_t nx;
	req_t   req;
	logic   to_proc;
	logic   to_bus;
	logic   shr;
	logic   miss;
	logic   upg;
	logic   err;
	logic   store;

	assign store = (evt.cmd == CMD_STORE);

	always_comb begin
		nx      = state;
		req     = REQ_NONE;
		to_proc = 1'b0;
		to_bus  = 1'b0;
		shr     = 1'b0;
		miss    = 1'b0;
		upg     = 1'b0;
		err     = 1'b0;
		unique case (evt.cmd) inside
			CMD_LOAD, CMD_STORE: begin
				unique case (state) inside
					ST_I: begin
						req  = store ? REQ_GETM : REQ_GETS;
						nx   = store ? ST_IM : ST_ISE;
						miss = 1'b1;
					end
					ST_S, ST_O, ST_F: begin
						if (store) begin
							req  = REQ_GETM;
							nx   = (state == ST_S) ? ST_SM :
								(state == ST_O) ? ST_OM : ST_FM;
							miss = 1'b1;
						end else begin
							to_proc = 1'b1;
						end
					end
					ST_E: begin
						to_proc = 1'b1;
						if (store) begin
							nx  = ST_M;
							upg = 1'b1;
						end
					end
					ST_M: to_proc = 1'b1;
					default: err = 1'b1;
				endcase
			end
			CMD_GETS, CMD_GETM, CMD_DATA: begin
				unique case (state) inside
					ST_I: ;
					ST_ISE: begin
						if (evt.cmd == CMD_DATA) begin
							to_proc = 1'b1;
							nx      = evt.shared_seen ? ST_S : ST_E;
						end
					end
					ST_IM: begin
						if (evt.cmd == CMD_DATA) begin
							to_proc = 1'b1;
							nx      = ST_M;
						end
					end
					ST_SM: begin
						if (evt.cmd == CMD_GETS) begin
							shr = 1'b1;
						end else if (evt.cmd == CMD_DATA) begin
							to_proc = 1'b1;
							nx      = ST_M;
						end
					end
					ST_FM, ST_OM: begin
						if (evt.cmd == CMD_GETS) begin
							shr    = 1'b1;
							to_bus = 1'b1;
						end else if (evt.cmd == CMD_GETM) begin
							to_bus = 1'b1;
							nx     = ST_IM;
						end else begin
							to_proc = 1'b1;
							nx      = ST_M;
						end
					end
					ST_S: begin
						if (evt.cmd == CMD_GETS) begin
							shr = 1'b1;
						end else if (evt.cmd == CMD_GETM) begin
							nx = ST_I;
						end else begin
							err = 1'b1;
						end
					end
					ST_E, ST_O, ST_M, ST_F: begin
						if (evt.cmd == CMD_GETS) begin
							shr    = 1'b1;
							to_bus = 1'b1;
							nx     = (state == ST_E || state == ST_F) ? ST_F : ST_O;
						end else if (evt.cmd == CMD_GETM) begin
							to_bus = 1'b1;
							nx     = ST_I;
						end else begin
							err = 1'b1;
						end
					end
					default: err = 1'b1;
				endcase
			end
			default: err = 1'b1;
		endcase
		if (err) begin
			nx      = state;
			req     = REQ_NONE;
			to_proc = 1'b0;
			to_bus  = 1'b0;
			shr     = 1'b0;
			miss    = 1'b0;
			upg     = 1'b0;
		end
	end

	always_comb begin
		res.bus_request       = req;
		res.data_to_processor = to_proc;
		res.data_onto_bus     = to_bus;
		res.dest_id           = to_bus ? evt.requester_id : '0;
		res.addr_out          = (req != REQ_NONE || to_proc || to_bus) ? evt.line_addr : '0;
		res.assert_shared     = shr;
		res.miss_pulse        = miss;
		res.upgrade_pulse     = upg;
		res.protocol_error    = err;
		res.line_state        = nx;
	end

endmodule

@@ src/moesif_checker.sv @@
// Port-level checks for the MOESIF line controller, bound to the top level.
// Depends on moesif_pkg and moesif_coherence_line_controller.
module moesif_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             evt_valid,
	input logic             evt_stall,
	input moesif_pkg::evt_t evt,
	input logic             res_valid,
	input logic             res_stall,
	input moesif_pkg::res_t res
);
	import moesif_pkg::*;

	// A stalled result transfer must hold its payload.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// An illegal event produces no bus or processor action.
	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.protocol_error |-> res.bus_request == REQ_NONE
			&& !res.data_to_processor && !res.data_onto_bus && !res.assert_shared
			&& !res.miss_pulse && !res.upgrade_pulse && res.addr_out == '0)
		else $error("protocol error with actions set");

	// A miss always issues a bus request and leaves the line waiting for data.
	a_miss_req: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.miss_pulse |-> res.bus_request != REQ_NONE
			&& (res.line_state == ST_ISE || res.line_state == ST_IM
			|| res.line_state == ST_SM || res.line_state == ST_FM
			|| res.line_state == ST_OM))
		else $error("miss without a bus request");

	// A silent upgrade completes the store and ends in M without bus traffic.
	a_upgrade: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.upgrade_pulse |-> res.line_state == ST_M
			&& res.data_to_processor && res.bus_request == REQ_NONE
			&& !res.data_onto_bus && res.dest_id == '0)
		else $error("bad silent upgrade result");

endmodule

bind moesif_coherence_line_controller moesif_checker u_checker (.*);

@@ tb/tb.sv @@
// Self-checking testbench for moesif_coherence_line_controller.
// It predicts each result from its own copy of the line state and checks the results in order.
// Depends on moesif_pkg and the controller RTL.
module tb;
	import moesif_pkg::*;

	localparam cmd_t CMD_UNUSED_LO   = 3'd5;
	localparam cmd_t CMD_UNUSED_MID  = 3'd6;
	localparam cmd_t CMD_UNUSED_HI   = 3'd7;
	localparam int   HOLD_OFF_CYCLES = 80;
	localparam int   IDLE_LIMIT      = 1000;
	localparam int   DRAIN_LIMIT     = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic evt_valid = 1'b0;
	logic evt_stall;
	evt_t evt = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	state_t model_state = ST_I;
	res_t   expected_results[$];
	int     mismatches = 0;
	int     events_sent = 0;
	int     results_checked = 0;
	int     errors_predicted = 0;
	logic [15:0] states_seen = '0;

	int burst_left = 0;
	bit gaps_on = 1'b1;
	bit rx_free = 1'b0;
	bit hold_off_go = 1'b0;
	int hold_left = 0;
	int stall_mode = 0;
	int mode_left = 0;
	int stall_phase = 0;
	int idle_cycles = 0;

	moesif_coherence_line_controller uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt       (evt),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always #1 clk = ~clk;

	function automatic res_t predict_line_event(input evt_t e, inout state_t st);
		res_t   r;
		state_t nx;
		logic   fault;
		logic   is_store;
		r = '0;
		nx = st;
		fault = 1'b0;
		is_store = (e.cmd == CMD_STORE);
		case (e.cmd)
			CMD_LOAD, CMD_STORE: begin
				case (st)
					ST_I: begin
						r.bus_request = is_store ? REQ_GETM : REQ_GETS;
						nx = is_store ? ST_IM : ST_ISE;
						r.miss_pulse = 1'b1;
					end
					ST_S, ST_O, ST_F: begin
						if (is_store) begin
							r.bus_request = REQ_GETM;
							nx = (st == ST_S) ? ST_SM : (st == ST_O) ? ST_OM : ST_FM;
							r.miss_pulse = 1'b1;
						end else begin
							r.data_to_processor = 1'b1;
						end
					end
					ST_E: begin
						r.data_to_processor = 1'b1;
						if (is_store) begin
							nx = ST_M;
							r.upgrade_pulse = 1'b1;
						end
					end
					ST_M: r.data_to_processor = 1'b1;
					default: fault = 1'b1;
				endcase
			end
			CMD_GETS, CMD_GETM, CMD_DATA: begin
				case (st)
					ST_I: ;
					ST_ISE: begin
						if (e.cmd == CMD_DATA) begin
							r.data_to_processor = 1'b1;
							nx = e.shared_seen ? ST_S : ST_E;
						end
					end
					ST_IM: begin
						if (e.cmd == CMD_DATA) begin
							r.data_to_processor = 1'b1;
							nx = ST_M;
						end
					end
					ST_SM: begin
						if (e.cmd == CMD_GETS) begin
							r.assert_shared = 1'b1;
						end else if (e.cmd == CMD_DATA) begin
							r.data_to_processor = 1'b1;
							nx = ST_M;
						end
					end
					ST_FM, ST_OM: begin
						if (e.cmd == CMD_GETS) begin
							r.assert_shared = 1'b1;
							r.data_onto_bus = 1'b1;
						end else if (e.cmd == CMD_GETM) begin
							r.data_onto_bus = 1'b1;
							nx = ST_IM;
						end else begin
							r.data_to_processor = 1'b1;
							nx = ST_M;
						end
					end
					ST_S: begin
						if (e.cmd == CMD_GETS)
							r.assert_shared = 1'b1;
						else if (e.cmd == CMD_GETM)
							nx = ST_I;
						else
							fault = 1'b1;
					end
					ST_E, ST_O, ST_M, ST_F: begin
						if (e.cmd == CMD_GETS) begin
							r.assert_shared = 1'b1;
							r.data_onto_bus = 1'b1;
							nx = (st == ST_E || st == ST_F) ? ST_F : ST_O;
						end else if (e.cmd == CMD_GETM) begin
							r.data_onto_bus = 1'b1;
							nx = ST_I;
						end else begin
							fault = 1'b1;
						end
					end
					default: fault = 1'b1;
				endcase
			end
			default: fault = 1'b1;
		endcase
		if (fault) begin
			r = '0;
			nx = st;
			r.protocol_error = 1'b1;
		end
		if (r.data_onto_bus)
			r.dest_id = e.requester_id;
		if (r.bus_request != REQ_NONE || r.data_to_processor || r.data_onto_bus)
			r.addr_out = e.line_addr;
		r.line_state = nx;
		st = nx;
		return r;
	endfunction

	function automatic evt_t make_event(input cmd_t c, input logic [ADDR_BITS-1:0] a,
			input logic [ID_BITS-1:0] id, input logic sh);
		evt_t e;
		e.cmd = c;
		e.line_addr = a;
		e.requester_id = id;
		e.shared_seen = sh;
		return e;
	endfunction

	// Mostly events that make sense in the current state, with some noise of any kind.
	function automatic evt_t random_event(input state_t st);
		evt_t e;
		int   roll;
		roll = $urandom_range(0, 99);
		if (roll < 10)
			e.cmd = cmd_t'($urandom_range(0, 7));
		else if (st == ST_ISE || st == ST_IM || st == ST_SM || st == ST_FM || st == ST_OM)
			e.cmd = (roll < 64) ? CMD_DATA : (roll < 82) ? CMD_GETS : CMD_GETM;
		else if (st == ST_I)
			e.cmd = (roll < 50) ? CMD_LOAD : (roll < 85) ? CMD_STORE :
				(roll < 92) ? CMD_GETS : (roll < 96) ? CMD_GETM : CMD_DATA;
		else
			e.cmd = (roll < 40) ? CMD_LOAD : (roll < 62) ? CMD_STORE :
				(roll < 80) ? CMD_GETS : (roll < 96) ? CMD_GETM : CMD_DATA;
		case ($urandom_range(0, 9))
			0: e.line_addr = '0;
			1: e.line_addr = '1;
			default: e.line_addr = ADDR_BITS'({$urandom, $urandom});
		endcase
		e.requester_id = ID_BITS'($urandom);
		e.shared_seen = 1'($urandom);
		return e;
	endfunction

	// Valid stays high after a transfer, so the caller sends the next event in the same step
	// or lowers valid itself.
	task automatic send_event(input evt_t e);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = gaps_on ? $urandom_range(0, 6) : 0;
			if (gap != 0) begin
				evt_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		evt_valid <= 1'b1;
		evt <= e;
		@(posedge clk);
		while (evt_stall)
			@(posedge clk);
		expected_results.push_back(predict_line_event(e, model_state));
		states_seen[model_state] = 1'b1;
		if (expected_results[$].protocol_error)
			errors_predicted++;
		events_sent++;
	endtask

	task automatic test_directed_walk();
		logic [ADDR_BITS-1:0] a;
		a = ADDR_BITS'({$urandom, $urandom});
		send_event(make_event(CMD_LOAD, '0, '0, 1'b0));
		send_event(make_event(CMD_STORE, a, '1, 1'b1));
		send_event(make_event(CMD_GETS, a, '1, 1'b0));
		send_event(make_event(CMD_DATA, '1, '0, 1'b1));
		send_event(make_event(CMD_GETS, a, '1, 1'b0));
		send_event(make_event(CMD_DATA, a, '0, 1'b0));
		send_event(make_event(CMD_STORE, '1, '0, 1'b0));
		send_event(make_event(CMD_GETM, a, '1, 1'b1));
		send_event(make_event(CMD_GETS, a, '1, 1'b0));
		send_event(make_event(CMD_LOAD, a, '0, 1'b0));
		send_event(make_event(CMD_DATA, '0, '1, 1'b1));
		send_event(make_event(CMD_UNUSED_LO, '1, '1, 1'b1));
		send_event(make_event(CMD_GETS, '1, '0, 1'b0));
		send_event(make_event(CMD_STORE, a, '0, 1'b0));
		send_event(make_event(CMD_GETS, a, '1, 1'b1));
		send_event(make_event(CMD_GETM, '1, '1, 1'b0));
		send_event(make_event(CMD_GETM, a, '0, 1'b0));
		send_event(make_event(CMD_DATA, a, '0, 1'b0));
		send_event(make_event(CMD_GETM, '0, '1, 1'b0));
		send_event(make_event(CMD_LOAD, '1, '0, 1'b0));
		send_event(make_event(CMD_DATA, a, '0, 1'b0));
		send_event(make_event(CMD_STORE, a, '1, 1'b1));
		send_event(make_event(CMD_UNUSED_MID, a, '0, 1'b0));
		send_event(make_event(CMD_UNUSED_HI, '1, '1, 1'b1));
	endtask

	task automatic test_random_traffic(input int count);
		repeat (count)
			send_event(random_event(model_state));
	endtask

	// The receiver holds off while events keep coming, so both registers fill and the
	// event channel stalls.
	task automatic test_output_hold_off(input int count);
		gaps_on = 1'b0;
		hold_off_go = 1'b1;
		repeat (count)
			send_event(random_event(model_state));
		gaps_on = 1'b1;
	endtask

	task automatic test_full_rate(input int count);
		gaps_on = 1'b0;
		rx_free = 1'b1;
		repeat (count)
			send_event(random_event(model_state));
		rx_free = 1'b0;
		gaps_on = 1'b1;
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (hold_off_go) begin
			hold_left = HOLD_OFF_CYCLES;
			hold_off_go = 1'b0;
		end
		if (hold_left != 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else if (rx_free) begin
			res_stall <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			stall_phase++;
			case (stall_mode)
				0: res_stall <= 1'b0;
				1: res_stall <= ($urandom_range(0, 4) == 0);
				2: res_stall <= ($urandom_range(0, 9) < 7);
				default: res_stall <= (stall_phase % 3 == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				$display("%0t: result with no event pending, expected none actual %p", $time, res);
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				check_field("bus_request", 64'(want.bus_request), 64'(res.bus_request));
				check_field("data_to_processor", 64'(want.data_to_processor),
					64'(res.data_to_processor));
				check_field("data_onto_bus", 64'(want.data_onto_bus), 64'(res.data_onto_bus));
				check_field("dest_id", 64'(want.dest_id), 64'(res.dest_id));
				check_field("addr_out", 64'(want.addr_out), 64'(res.addr_out));
				check_field("assert_shared", 64'(want.assert_shared), 64'(res.assert_shared));
				check_field("miss_pulse", 64'(want.miss_pulse), 64'(res.miss_pulse));
				check_field("upgrade_pulse", 64'(want.upgrade_pulse), 64'(res.upgrade_pulse));
				check_field("protocol_error", 64'(want.protocol_error),
					64'(res.protocol_error));
				check_field("line_state", 64'(want.line_state), 64'(res.line_state));
			end
		end
	end

	always @(posedge clk) begin
		if ((evt_valid && !evt_stall) || (res_valid && !res_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int n;
		int leftover;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_walk();
		test_random_traffic(1450);
		test_output_hold_off(200);
		test_full_rate(280);
		evt_valid <= 1'b0;
		for (n = 0; n < DRAIN_LIMIT && expected_results.size() != 0; n++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		leftover = expected_results.size();
		if (leftover != 0) begin
			mismatches++;
			$display("%0t: %0d expected results never arrived", $time, leftover);
		end
		$display("Covered %0d events and %0d checked results, %0d of them protocol errors.",
			events_sent, results_checked, errors_predicted);
		$display("The line reached %0d of its 11 states, under random gaps and output stalls.",
			$countones(states_seen | 16'h0001));
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
